// ===== src/qlt_pkg.sv =====
// shared types, constants and helper functions for the query language tokenizer
// no dependencies; imported by every module of the block

package qlt_pkg;

  // defaults for top-level parameters
  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // fixed field widths of a token
  localparam int KIND_W  = 5;
  localparam int START_W = 24;
  localparam int LEN_W   = 16;
  localparam int LNUM_W  = 20;
  localparam int CNUM_W  = 16;
  localparam int MANT_W  = 63;
  localparam int FRACD_W = 8;
  localparam int COLX_W  = 32;   // raw column counter, zero-extended
  localparam int SUB_W   = 17;   // amount taken off the column
  localparam int FIELDS_W = START_W + LEN_W + LNUM_W + CNUM_W + MANT_W + FRACD_W + 2;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int NUM_KW   = 5;

  localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_UNDER  = "_";

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING,
    M_LT, M_GT, M_EQ, M_BANG
  } scan_mode_t;

  typedef enum logic [KIND_W-1:0] {
    K_FROM = 5'd0, K_FILTER, K_SELECT, K_WRITE, K_NOT, K_IDENT, K_NUMBER, K_STRING,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_EQEQ, K_NEQ, K_LT, K_GT, K_LE, K_GE,
    K_COMMA, K_LPAREN, K_RPAREN, K_EOF
  } token_kind_t;

  // one token as it sits in the queue, column not yet clamped
  typedef struct packed {
    token_kind_t         kind;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [LNUM_W-1:0]   line;
    logic [COLX_W-1:0]   col;
    logic [SUB_W-1:0]    sub;
    logic [MANT_W-1:0]   mant;
    logic [FRACD_W-1:0]  frac;
    logic                is_frac;
    logic                ovf;
    logic                last;
  } token_rec_t;

  // queue write strobes; second is only set together with first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    is_op = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
            (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic token_kind_t op_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:   op_kind = K_PLUS;
      CH_MINUS:  op_kind = K_MINUS;
      CH_STAR:   op_kind = K_STAR;
      CH_SLASH:  op_kind = K_SLASH;
      CH_COMMA:  op_kind = K_COMMA;
      CH_LPAREN: op_kind = K_LPAREN;
      default:   op_kind = K_RPAREN;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0:    kw_len = 3'd4;
      3'd1:    kw_len = 3'd6;
      3'd2:    kw_len = 3'd6;
      3'd3:    kw_len = 3'd5;
      3'd4:    kw_len = 3'd3;
      default: kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [47:0] w;
    case (k)
      3'd0:    w = {"from", 16'h0};
      3'd1:    w = "filter";
      3'd2:    w = "select";
      3'd3:    w = {"write", 8'h0};
      3'd4:    w = {"not", 24'h0};
      default: w = 48'h0;
    endcase
    if (p <= 3'd5) begin
      kw_char = w[(47 - 8 * p) -: 8];
    end else begin
      kw_char = 8'h0;
    end
  endfunction

  // keyword k still possible when byte c sits at position p
  function automatic logic kw_match(input logic [2:0] k, input logic [LEN_W-1:0] p,
                                    input logic [7:0] c);
    kw_match = (p < LEN_W'(kw_len(k))) && (kw_char(k, p[2:0]) == c);
  endfunction

  // acc*10 + digit with saturation; returns {overflow, mantissa}
  function automatic logic [MANT_W:0] add_digit(input logic [MANT_W-1:0] acc, input logic ovf,
                                                input logic [7:0] c);
    logic [MANT_W+3:0] wide;
    logic [MANT_W+3:0] prod;
    wide = {4'b0, acc};
    prod = (wide << 3) + (wide << 1) + {{MANT_W{1'b0}}, c[3:0]};
    if (ovf || (prod[MANT_W+3:MANT_W] != 4'h0)) begin
      add_digit = {1'b1, MANT_MAX};
    end else begin
      add_digit = {1'b0, prod[MANT_W-1:0]};
    end
  endfunction

endpackage

// ===== src/query_language_tokenizer.sv =====
// Streaming tokenizer for a small query language.
// Input: one source byte per transaction on s_tdata; s_tlast marks the end of the
// source (the byte is ignored, any pending token is flushed and one EOF token follows).
// Output: one token per transaction; m_tuser holds the token kind, m_tdata the offset,
// length, line, column and number fields, m_tlast marks the last token caused by
// one input byte.
// A completed token passes through the queue write, then the output register, before
// it shows on m_tvalid.
// Throughput: one byte per cycle. A byte yields at most two tokens; they go into a
// four-entry queue drained by the output register at one token per cycle. s_tready
// drops while fewer than two queue entries are free, so a stalled receiver fills
// the queue and then holds off the source; nothing is lost.
// Reset (rst, synchronous): the scanner returns to idle at offset 0, line 1,
// column 1 and the queue and output register empty. The end marker restores the
// same scanner state.
// depends on qlt_pkg, qlt_lexer, qlt_queue, qlt_emitter

module query_language_tokenizer import qlt_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] char_in
  input  logic               s_tlast,   // end_of_input
  output logic               m_tvalid,
  input  logic               m_tready,
  // [23:0] start_offset, [39:24] lexeme_length, [59:40] line_number,
  // [75:60] column_number, [138:76] number_mantissa, [146:139] fraction_digits,
  // [147] is_fraction, [148] mantissa_overflow, [151:149] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]  m_tuser,   // [4:0] token_kind
  output logic               m_tlast    // last_of_run
);

  logic       fire, pop, head_valid, room;
  push_t      push;
  token_rec_t rec0, rec1, head;

  assign s_tready = room;
  assign fire     = s_tvalid && s_tready;

  qlt_lexer #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_in      (s_tdata),
    .end_of_input (s_tlast),
    .push         (push),
    .rec0         (rec0),
    .rec1         (rec1)
  );

  qlt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rec0       (rec0),
    .rec1       (rec1),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  qlt_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // a second token in one cycle only comes with a first
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second queue write without first");

  // the end marker always produces at least the EOF token
  a_eof_pushed: assert property (@(posedge clk) disable iff (rst)
    (fire && s_tlast) |-> push.first)
    else $error("end marker produced no token");

  // EOF is always the final token of its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == K_EOF)) |-> m_tlast)
    else $error("EOF token not marked last");

  // emitter only pops a filled queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== src/qlt_lexer.sv =====
// front end: scans one source byte per accepted transaction and builds token records
// depends on qlt_pkg; feeds up to two records per byte into qlt_queue

module qlt_lexer import qlt_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] char_in,
  input  logic       end_of_input,
  output push_t      push,
  output token_rec_t rec0,
  output token_rec_t rec1
);

  scan_mode_t              mode, mode_next;
  logic [OFFSET_BITS-1:0]  byte_offset, offset_next;
  logic [LINE_BITS-1:0]    line_count, line_next;
  logic [COLUMN_BITS-1:0]  column_count, col_next;
  logic [OFFSET_BITS-1:0]  token_start, tstart_next;
  logic [LEN_W-1:0]        token_length, tlen_next;
  logic [NUM_KW-1:0]       kw_cand, cand_next;
  logic [MANT_W-1:0]       mantissa, mant_next;
  logic [FRACD_W-1:0]      frac_count, frac_next;
  logic                    ovf, ovf_next;

  logic [OFFSET_BITS-1:0]  off_inc;
  logic [LINE_BITS-1:0]    line_sat;
  logic [COLUMN_BITS-1:0]  col_sat;
  logic [LEN_W-1:0]        len_sat1, len_sat2;
  logic [FRACD_W-1:0]      frac_sat;
  logic [NUM_KW-1:0]       cand_upd, cand_first;
  logic [MANT_W:0]         digit_res;
  logic [31:0]             line_ext;
  logic is_dig, is_alp, is_nl, is_quote, is_cmp_start, handled, go_idle;

  logic        flush_emit, b_emit;
  token_rec_t  flush_rec, b_rec;
  token_kind_t ident_kind;

  assign off_inc  = byte_offset + OFFSET_BITS'(1);
  assign line_sat = (line_count == {LINE_BITS{1'b1}}) ? line_count : line_count + LINE_BITS'(1);
  assign col_sat  = (column_count == {COLUMN_BITS{1'b1}}) ? column_count
                                                          : column_count + COLUMN_BITS'(1);
  assign len_sat1 = (token_length == {LEN_W{1'b1}}) ? token_length : token_length + LEN_W'(1);
  assign len_sat2 = (token_length >= {{(LEN_W-1){1'b1}}, 1'b0}) ? {LEN_W{1'b1}}
                                                               : token_length + LEN_W'(2);
  assign frac_sat = (frac_count == {FRACD_W{1'b1}}) ? frac_count : frac_count + FRACD_W'(1);
  assign digit_res = add_digit(mantissa, ovf, char_in);
  assign line_ext  = 32'(line_count);

  assign is_dig   = is_digit(char_in);
  assign is_alp   = is_alpha(char_in);
  assign is_nl    = (char_in == CH_LF);
  assign is_quote = (char_in == CH_QUOTE);
  assign is_cmp_start = (char_in == CH_LT) || (char_in == CH_GT) ||
                        (char_in == CH_EQ) || (char_in == CH_BANG);

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cand_upd[k]   = kw_cand[k] & kw_match(3'(k), token_length, char_in);
      cand_first[k] = kw_match(3'(k), {LEN_W{1'b0}}, char_in);
    end
  end

  // does the pending mode swallow this byte
  always_comb begin
    case (mode)
      M_COMMENT, M_STRING:         handled = 1'b1;
      M_IDENT:                     handled = is_alp || is_dig;
      M_INT:                       handled = is_dig || (char_in == CH_DOT);
      M_DOT, M_FRAC:               handled = is_dig;
      M_LT, M_GT, M_EQ, M_BANG:    handled = (char_in == CH_EQ);
      default:                     handled = 1'b0;
    endcase
  end

  assign go_idle = (mode == M_IDLE) || !handled;

  // next state
  always_comb begin
    mode_next   = mode;
    offset_next = byte_offset;
    line_next   = line_count;
    col_next    = column_count;
    tstart_next = token_start;
    tlen_next   = token_length;
    cand_next   = kw_cand;
    mant_next   = mantissa;
    frac_next   = frac_count;
    ovf_next    = ovf;
    if (end_of_input) begin
      mode_next   = M_IDLE;
      offset_next = '0;
      line_next   = LINE_BITS'(1);
      col_next    = COLUMN_BITS'(1);
      tstart_next = '0;
      tlen_next   = '0;
      cand_next   = '1;
      mant_next   = '0;
      frac_next   = '0;
      ovf_next    = 1'b0;
    end else if (!go_idle) begin
      offset_next = off_inc;
      col_next    = col_sat;
      case (mode)
        M_COMMENT: begin
          if (is_nl) begin
            line_next = line_sat;
            col_next  = COLUMN_BITS'(1);
            mode_next = M_IDLE;
          end
        end
        M_IDENT: begin
          cand_next = cand_upd;
          tlen_next = len_sat1;
        end
        M_INT: begin
          if (is_dig) begin
            tlen_next = len_sat1;
            {ovf_next, mant_next} = digit_res;
          end else begin
            mode_next = M_DOT;
          end
        end
        M_DOT: begin
          tlen_next = len_sat2;
          {ovf_next, mant_next} = digit_res;
          frac_next = FRACD_W'(1);
          mode_next = M_FRAC;
        end
        M_FRAC: begin
          tlen_next = len_sat1;
          {ovf_next, mant_next} = digit_res;
          frac_next = frac_sat;
        end
        M_STRING: begin
          if (is_quote) begin
            mode_next = M_IDLE;
          end else if (is_nl) begin
            line_next = line_sat;
            col_next  = COLUMN_BITS'(1);
            tlen_next = len_sat1;
          end else begin
            tlen_next = len_sat1;
          end
        end
        M_LT, M_GT, M_EQ, M_BANG: begin
          mode_next = M_IDLE;
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase
    end else begin
      // fresh byte, any pending token has been flushed
      mode_next   = M_IDLE;
      offset_next = off_inc;
      if (is_nl) begin
        line_next = line_sat;
        col_next  = COLUMN_BITS'(1);
      end else begin
        col_next = col_sat;
        if (is_quote || is_cmp_start || is_alp || is_dig) begin
          tstart_next = byte_offset;
          tlen_next   = '0;
          cand_next   = '1;
          mant_next   = '0;
          frac_next   = '0;
          ovf_next    = 1'b0;
        end
        if (char_in == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (is_quote) begin
          tstart_next = off_inc;
          mode_next   = M_STRING;
        end else if (char_in == CH_LT) begin
          mode_next = M_LT;
        end else if (char_in == CH_GT) begin
          mode_next = M_GT;
        end else if (char_in == CH_EQ) begin
          mode_next = M_EQ;
        end else if (char_in == CH_BANG) begin
          mode_next = M_BANG;
        end else if (is_alp) begin
          cand_next = cand_first;
          tlen_next = LEN_W'(1);
          mode_next = M_IDENT;
        end else if (is_dig) begin
          tlen_next = LEN_W'(1);
          mant_next = {{(MANT_W-4){1'b0}}, char_in[3:0]};
          mode_next = M_INT;
        end
      end
    end
  end

  function automatic token_rec_t mk_rec(input token_kind_t kind,
                                        input logic [OFFSET_BITS-1:0] start,
                                        input logic [LEN_W-1:0] len,
                                        input logic [SUB_W-1:0] sub,
                                        input logic [COLUMN_BITS-1:0] col,
                                        input logic num);
    token_rec_t r;
    logic [31:0] start_ext;
    start_ext = 32'(start);
    r.kind    = kind;
    r.start   = start_ext[START_W-1:0];
    r.len     = len;
    r.line    = line_ext[LNUM_W-1:0];
    r.col     = COLX_W'(col);
    r.sub     = sub;
    r.mant    = num ? mantissa : '0;
    r.frac    = num ? frac_count : '0;
    r.is_frac = num && (mode == M_FRAC);
    r.ovf     = num && ovf;
    r.last    = 1'b0;
    mk_rec = r;
  endfunction

  always_comb begin
    ident_kind = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_cand[k] && (token_length == LEN_W'(kw_len(3'(k))))) begin
        ident_kind = token_kind_t'(KIND_W'(k));
      end
    end
  end

  // outputs: the flushed token and the token this byte produces
  always_comb begin
    flush_emit = 1'b0;
    flush_rec  = mk_rec(K_IDENT, token_start, token_length, SUB_W'(token_length),
                        column_count, 1'b0);
    if (end_of_input || go_idle) begin
      case (mode)
        M_IDENT: begin
          flush_emit = 1'b1;
          flush_rec  = mk_rec(ident_kind, token_start, token_length, SUB_W'(token_length),
                              column_count, 1'b0);
        end
        M_INT, M_FRAC: begin
          flush_emit = 1'b1;
          flush_rec  = mk_rec(K_NUMBER, token_start, token_length, SUB_W'(token_length),
                              column_count, 1'b1);
        end
        M_DOT: begin
          // trailing point is not part of the lexeme but moved the column
          flush_emit = 1'b1;
          flush_rec  = mk_rec(K_NUMBER, token_start, token_length,
                              SUB_W'(token_length) + SUB_W'(1), column_count, 1'b1);
        end
        M_LT: begin
          flush_emit = 1'b1;
          flush_rec  = mk_rec(K_LT, token_start, LEN_W'(1), SUB_W'(1), column_count, 1'b0);
        end
        M_GT: begin
          flush_emit = 1'b1;
          flush_rec  = mk_rec(K_GT, token_start, LEN_W'(1), SUB_W'(1), column_count, 1'b0);
        end
        default: flush_emit = 1'b0;
      endcase
    end

    b_emit = 1'b0;
    b_rec  = mk_rec(K_EOF, byte_offset, '0, '0, column_count, 1'b0);
    if (end_of_input) begin
      b_emit = 1'b1;
    end else if (!go_idle) begin
      case (mode)
        M_STRING: begin
          b_emit = is_quote;
          b_rec  = mk_rec(K_STRING, token_start, token_length,
                          SUB_W'(token_length) + SUB_W'(2), col_sat, 1'b0);
        end
        M_LT: begin
          b_emit = 1'b1;
          b_rec  = mk_rec(K_LE, token_start, LEN_W'(2), SUB_W'(2), col_sat, 1'b0);
        end
        M_GT: begin
          b_emit = 1'b1;
          b_rec  = mk_rec(K_GE, token_start, LEN_W'(2), SUB_W'(2), col_sat, 1'b0);
        end
        M_EQ: begin
          b_emit = 1'b1;
          b_rec  = mk_rec(K_EQEQ, token_start, LEN_W'(2), SUB_W'(2), col_sat, 1'b0);
        end
        M_BANG: begin
          b_emit = 1'b1;
          b_rec  = mk_rec(K_NEQ, token_start, LEN_W'(2), SUB_W'(2), col_sat, 1'b0);
        end
        default: b_emit = 1'b0;
      endcase
    end else if (is_op(char_in)) begin
      b_emit = 1'b1;
      b_rec  = mk_rec(op_kind(char_in), byte_offset, LEN_W'(1), SUB_W'(1), col_sat, 1'b0);
    end

    push.first  = fire && (flush_emit || b_emit);
    push.second = fire && flush_emit && b_emit;
    rec0        = flush_emit ? flush_rec : b_rec;
    rec0.last   = !(flush_emit && b_emit);
    rec1        = b_rec;
    rec1.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      byte_offset  <= '0;
      line_count   <= LINE_BITS'(1);
      column_count <= COLUMN_BITS'(1);
      token_start  <= '0;
      token_length <= '0;
      kw_cand      <= '1;
      mantissa     <= '0;
      frac_count   <= '0;
      ovf          <= 1'b0;
    end else if (fire) begin
      mode         <= mode_next;
      byte_offset  <= offset_next;
      line_count   <= line_next;
      column_count <= col_next;
      token_start  <= tstart_next;
      token_length <= tlen_next;
      kw_cand      <= cand_next;
      mantissa     <= mant_next;
      frac_count   <= frac_next;
      ovf          <= ovf_next;
    end
  end

endmodule

// ===== src/qlt_queue.sv =====
// token queue between the lexer and the emitter: two writes and one read per cycle
// depends on qlt_pkg for the record and push types

module qlt_queue import qlt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  input  token_rec_t rec0,
  input  token_rec_t rec1,
  input  logic       pop,
  output token_rec_t head,
  output logic       head_valid,
  output logic       room
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next, wa1;
  logic [CNT_W-1:0] count, count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wa1        = ptr_inc(wr_ptr);
  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  // room for a worst-case byte that yields two tokens
  assign room       = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.second) begin
      wr_ptr_next = ptr_inc(wa1);
    end else if (push.first) begin
      wr_ptr_next = wa1;
    end
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= rec0;
    end
    if (push.second) begin
      slots[wa1] <= rec1;
    end
  end

endmodule

// ===== src/qlt_emitter.sv =====
// back end: pops token records, clamps the column and drives the output stream register
// depends on qlt_pkg; reads from qlt_queue

module qlt_emitter import qlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  token_rec_t         head,
  input  logic               head_valid,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]  m_tuser,
  output logic               m_tlast
);

  localparam int DIFF_W = COLX_W + 2;
  localparam int PAD_W  = TDATA_W - FIELDS_W;
  localparam logic signed [DIFF_W-1:0] COL_MIN = -(DIFF_W'(2) ** (CNUM_W - 1));
  localparam logic signed [DIFF_W-1:0] COL_MAX = (DIFF_W'(2) ** (CNUM_W - 1)) - DIFF_W'(1);

  logic                     load;
  logic signed [DIFF_W-1:0] diff;
  logic [CNUM_W-1:0]        col_out;

  assign load = !m_tvalid || m_tready;
  assign pop  = head_valid && load;

  assign diff = $signed({2'b00, head.col}) - $signed({{(DIFF_W-SUB_W){1'b0}}, head.sub});

  always_comb begin
    if (diff < COL_MIN) begin
      col_out = {1'b1, {(CNUM_W-1){1'b0}}};
    end else if (diff > COL_MAX) begin
      col_out = {1'b0, {(CNUM_W-1){1'b1}}};
    end else begin
      col_out = diff[CNUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {{PAD_W{1'b0}}, head.ovf, head.is_frac, head.frac, head.mant, col_out,
                  head.line, head.len, head.start};
      m_tuser <= head.kind;
      m_tlast <= head.last;
    end
  end

endmodule
